// File: hdl/hkr_pkg.sv
// ----------------------------------------------------------------------------
// HID keyboard report builder package
// Shared types and constants for the boot keyboard report logic.
// ----------------------------------------------------------------------------
package hkr_pkg;

  // Report layout.
  localparam int NumSlots = 6;
  localparam int SlotIdxW = $clog2(NumSlots);

  // Key code ranges: modifier keys sit at the top of the valid range.
  localparam logic [7:0] ModFirst = 8'hE0;
  localparam logic [7:0] ModLast  = 8'hE7;

  // Default for the auto-report register.
  localparam logic AutoReportReset = 1'b1;

  // Operation codes.
  typedef enum logic [2:0] {
    OpPress        = 3'd0,
    OpPressMask    = 3'd1,
    OpMaskPress    = 3'd2,
    OpRelease      = 3'd3,
    OpReleaseMask  = 3'd4,
    OpMaskRelease  = 3'd5,
    OpReleaseAll   = 3'd6,
    OpSend         = 3'd7
  } op_t;

  typedef logic [7:0] key_slots_t [NumSlots];

  // One captured input item.
  typedef struct packed {
    op_t        opcode;
    logic [7:0] key_code;
    logic [7:0] modifier_mask;
  } hkr_item_t;

  // Status of one processed item.
  typedef struct packed {
    logic success;
    logic report_sent;
  } hkr_status_t;

endpackage

// File: hdl/hid_keyboard_report_builder.sv
// ----------------------------------------------------------------------------
// HID keyboard report builder
// Keeps a boot keyboard report (modifier byte, six key slots) and returns
// the updated report with status for every command.
// An input register in front of the update logic captures each accepted
// command, and a result register behind it raises done with the status,
// while the report state is updated from the same captured command.
// Throughput: one command per cycle; busy stays low.
// Reset clears the report, empties the pipeline and sets auto-report.
// The receiver cannot stall; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module hid_keyboard_report_builder import hkr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] opcode,
  input  logic [7:0] key_code,
  input  logic [7:0] modifier_mask,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  output logic       done,
  output logic       success,
  output logic       report_sent,
  output logic [7:0] modifiers_out,
  output logic [7:0] slot0,
  output logic [7:0] slot1,
  output logic [7:0] slot2,
  output logic [7:0] slot3,
  output logic [7:0] slot4,
  output logic [7:0] slot5
);

  logic        auto_report;
  logic        item_valid;
  hkr_item_t   item;
  logic [7:0]  mods;
  key_slots_t  slots;
  logic [7:0]  mods_next;
  key_slots_t  slots_next;
  hkr_status_t status;
  hkr_status_t status_q;

  // The pipeline takes a command and a register write in every cycle.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Auto-report register.
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_report <= AutoReportReset;
    end else if (cfg_valid && cfg_ready) begin
      auto_report <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= start && !busy;
    end
    if (start && !busy) begin
      item.opcode        <= op_t'(opcode);
      item.key_code      <= key_code;
      item.modifier_mask <= modifier_mask;
    end
  end

  hkr_update u_update (
    .item        (item),
    .mods        (mods),
    .slots       (slots),
    .auto_report (auto_report),
    .mods_next   (mods_next),
    .slots_next  (slots_next),
    .status      (status)
  );

  // Report state, updated once per captured command.
  always_ff @(posedge clk) begin
    if (rst) begin
      mods <= 8'd0;
      for (int i = 0; i < NumSlots; i++) begin
        slots[i] <= 8'd0;
      end
    end else if (item_valid) begin
      mods  <= mods_next;
      slots <= slots_next;
    end
  end

  // Result register: status with the transfer, report read from the state.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= item_valid;
    end
    if (item_valid) begin
      status_q <= status;
    end
  end

  assign success       = status_q.success;
  assign report_sent   = status_q.report_sent;
  assign modifiers_out = mods;
  assign slot0         = slots[0];
  assign slot1         = slots[1];
  assign slot2         = slots[2];
  assign slot3         = slots[3];
  assign slot4         = slots[4];
  assign slot5         = slots[5];

endmodule

// File: hdl/hkr_update.sv
// ----------------------------------------------------------------------------
// HID keyboard report update
// Applies one operation to the modifier byte and the six key slots and
// produces the success and report flags.
// ----------------------------------------------------------------------------
module hkr_update import hkr_pkg::*; (
  input  hkr_item_t   item,
  input  logic [7:0]  mods,
  input  key_slots_t  slots,
  input  logic        auto_report,
  output logic [7:0]  mods_next,
  output key_slots_t  slots_next,
  output hkr_status_t status
);

  logic                code_bad;
  logic                is_mod;
  logic [7:0]          mod_bit;
  logic                held;
  logic                free_found;
  logic [SlotIdxW-1:0] free_idx;
  logic                ok;

  // Classify the key code.
  assign code_bad = (item.key_code == 8'd0) || (item.key_code > ModLast);
  assign is_mod   = (item.key_code >= ModFirst);
  assign mod_bit  = 8'(1) << item.key_code[2:0];

  // Compare all slots in parallel; lowest empty slot wins.
  always_comb begin
    held       = 1'b0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (slots[i] == item.key_code) begin
        held = 1'b1;
      end
      if (slots[i] == 8'd0) begin
        free_found = 1'b1;
        free_idx   = SlotIdxW'(i);
      end
    end
  end

  // Operation decode and state update.
  always_comb begin
    mods_next  = mods;
    slots_next = slots;
    ok         = 1'b1;
    case (item.opcode)
      OpPress, OpPressMask: begin
        if (code_bad) begin
          ok = 1'b0;
        end else if (is_mod) begin
          mods_next = mods | mod_bit;
        end else if (held || !free_found) begin
          ok = 1'b0;
        end else begin
          slots_next[free_idx] = item.key_code;
        end
        if (ok && (item.opcode == OpPressMask)) begin
          mods_next = mods_next | item.modifier_mask;
        end
      end
      OpRelease, OpReleaseMask: begin
        if (code_bad) begin
          ok = 1'b0;
        end else if (is_mod) begin
          mods_next = mods & ~mod_bit;
        end else begin
          for (int i = 0; i < NumSlots; i++) begin
            if (slots[i] == item.key_code) begin
              slots_next[i] = 8'd0;
            end
          end
        end
        if (ok && (item.opcode == OpReleaseMask)) begin
          mods_next = mods_next & ~item.modifier_mask;
        end
      end
      OpMaskPress: begin
        mods_next = mods | item.modifier_mask;
      end
      OpMaskRelease: begin
        mods_next = mods & ~item.modifier_mask;
      end
      OpReleaseAll: begin
        mods_next = 8'd0;
        for (int i = 0; i < NumSlots; i++) begin
          slots_next[i] = 8'd0;
        end
      end
      default: begin
        // Send leaves the report unchanged.
      end
    endcase
  end

  // A send always transmits; anything else transmits on success with auto-report.
  assign status.success     = ok;
  assign status.report_sent = (item.opcode == OpSend) || (ok && auto_report);

endmodule
